### rtl/mono_framebuffer_draw_engine_top_defines.svh
// Assertion macros for the monochrome framebuffer draw engine.
// Included by the top level; relies on clk and arst_n being in scope.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_TOP_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MFDE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mfde assertion failed");
`define MFDE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mfde assertion failed");
`else
`define MFDE_ASSERT_IMP(lbl, ante, cons)
`define MFDE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/mfde_pkg.sv
// Shared constants, codes and types of the monochrome framebuffer draw engine.
// No dependencies; imported by every module of the block.
`default_nettype none
package mfde_pkg;
	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_HEIGHT = 256;
	localparam int GLYPH_BYTES  = 4096;

	localparam int FRAME_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
	localparam int FB_AW       = $clog2(FRAME_BYTES);
	localparam int GA_W        = $clog2(GLYPH_BYTES);
	localparam int LIN_W       = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1);
	localparam int XW          = $clog2(PANEL_WIDTH + 1);
	localparam int YW          = $clog2(PANEL_HEIGHT + 1);
	// Sum of a 16-bit coordinate and a 16-bit extent.
	localparam int EXT_W       = 17;
	// Glyph byte address: covers (95 * 63 + 62) and the largest font store.
	localparam int FA_W        = 14;
	localparam int FB_CMP_W    = ((FB_AW > 12) ? FB_AW : 12) + 1;

	localparam logic [2:0] KIND_FILL      = 3'd0;
	localparam logic [2:0] KIND_GLYPH_XY  = 3'd1;
	localparam logic [2:0] KIND_GLYPH_PEN = 3'd2;
	localparam logic [2:0] KIND_FONT      = 3'd3;
	localparam logic [2:0] KIND_READ      = 3'd4;

	localparam logic [0:0] CFG_GLYPH_WIDTH  = 1'b0;
	localparam logic [0:0] CFG_GLYPH_HEIGHT = 1'b1;

	localparam logic [5:0] GLYPH_DIM_RESET = 6'd8;
	localparam logic [3:0] MAX_GLYPH_COLS  = 4'd8;
	localparam logic [7:0] FIRST_CHAR      = 8'h20;
	localparam logic [7:0] LAST_CHAR       = 8'h7F;
	localparam logic [7:0] FB_WHITE        = 8'hFF;

	localparam logic [FB_AW-1:0]        LAST_BYTE  = FB_AW'(FRAME_BYTES - 1);
	localparam logic [LIN_W-1:0]        ROW_STEP   = LIN_W'(PANEL_WIDTH);
	localparam logic signed [EXT_W-1:0] X_LIMIT    = EXT_W'(PANEL_WIDTH);
	localparam logic signed [EXT_W-1:0] Y_LIMIT    = EXT_W'(PANEL_HEIGHT);
	localparam logic [FA_W-1:0]         FONT_LIMIT = FA_W'(GLYPH_BYTES);
	localparam logic [FB_CMP_W-1:0]     FRAME_LIMIT = FB_CMP_W'(FRAME_BYTES);

	// Controls for one read-modify-write of a framebuffer byte.
	typedef struct packed {
		logic       ink;
		logic       use_glyph;
		logic [2:0] lo;
		logic [2:0] hi;
		logic [3:0] off;
	} bu_ctrl_t;
endpackage
`default_nettype wire

### rtl/mfde_frame_ram.sv
// Framebuffer byte store: one write port, one registered read port.
// Depends on mfde_pkg for its depth and address width.
`default_nettype none
module mfde_frame_ram import mfde_pkg::*; (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [FB_AW-1:0] waddr,
	input  wire logic [7:0]       wdata,
	input  wire logic             re,
	input  wire logic [FB_AW-1:0] raddr,
	output logic      [7:0]       rdata
);
	logic [7:0] mem [FRAME_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### rtl/mfde_font_ram.sv
// Font byte store: one write port, one registered read port.
// Depends on mfde_pkg for its depth and address width.
`default_nettype none
module mfde_font_ram import mfde_pkg::*; (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [GA_W-1:0] waddr,
	input  wire logic [7:0]      wdata,
	input  wire logic            re,
	input  wire logic [GA_W-1:0] raddr,
	output logic      [7:0]      rdata
);
	logic [7:0] mem [GLYPH_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### rtl/mfde_byte_unit.sv
// Shared pixel unit: builds the span mask and glyph pattern for one byte and merges ink.
// Depends on mfde_pkg for bu_ctrl_t.
`default_nettype none
module mfde_byte_unit import mfde_pkg::*; (
	input  wire bu_ctrl_t   ctrl,
	input  wire logic [7:0] old_byte,
	input  wire logic [7:0] glyph_row,
	output logic      [7:0] new_byte
);
	logic [7:0] mask;
	logic [7:0] pattern;
	logic [7:0] sel;
	logic [3:0] off_neg;

	always_comb begin
		mask    = (8'hFF >> ctrl.lo) & (8'hFF << (3'd7 - ctrl.hi));
		off_neg = 4'd0 - ctrl.off;
		// A negative offset means the byte starts left of glyph column 0.
		if (!ctrl.use_glyph) begin
			pattern = 8'hFF;
		end else if (ctrl.off[3]) begin
			pattern = glyph_row >> off_neg[2:0];
		end else begin
			pattern = glyph_row << ctrl.off[2:0];
		end
		sel      = mask & pattern;
		new_byte = ctrl.ink ? (old_byte | sel) : (old_byte & ~sel);
	end
endmodule
`default_nettype wire

### rtl/mono_framebuffer_draw_engine_top.sv
// Monochrome framebuffer draw engine: sequencer, clipping and pen logic; uses mfde_pkg,
// mfde_frame_ram, mfde_font_ram, mfde_byte_unit and the defines header.
// After reset the framebuffer is swept to white, busy high throughout.
// Font load, skipped character and unused kinds: done in the cycle after start; read: ST_RD, ST_RDOUT.
// Fill and glyph: ST_SET1, ST_SET2 (done there if the clip is empty), ST_SET3, then per visible
// row ST_ROW and per touched byte ST_BRD, ST_BWR, then done. One command at a time; done cannot be stalled.
`default_nettype none
`include "mono_framebuffer_draw_engine_top_defines.svh"
module mono_framebuffer_draw_engine_top import mfde_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         kind,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] rect_w,
	input  wire logic signed [15:0] rect_h,
	input  wire logic               ink,
	input  wire logic [7:0]         char_code,
	input  wire logic [11:0]        font_addr,
	input  wire logic [7:0]         font_data,
	input  wire logic [11:0]        fb_addr,
	input  wire logic               cfg_we,
	input  wire logic [0:0]         cfg_idx,
	input  wire logic [5:0]         cfg_wdata,
	output logic                    done,
	output logic [7:0]              read_data,
	output logic                    status
);
	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_SET1, ST_SET2, ST_SET3,
		ST_ROW, ST_BRD, ST_BWR, ST_RD, ST_RDOUT
	} state_t;

	state_t state_q;
	logic   done_q;
	logic [7:0] read_data_q;
	logic   status_q;
	logic [FB_AW-1:0] clr_q;
	logic [5:0] gw_q, gh_q;
	logic signed [15:0] pen_x_q, pen_y_q;

	// Datapath registers.
	logic signed [15:0] ox_q, oy_q, ew_q, eh_q;
	logic ink_q, glyph_q, rd_ok_q, font_oob_q;
	logic [7:0] char_q;
	logic signed [EXT_W-1:0] xe_q, ye_q;
	logic [12:0] base_q;
	logic [XW-1:0] x0_q, x1_q;
	logic [YW-1:0] y0_q, y1_q, row_q;
	logic [LIN_W-1:0] rowbase_q;
	logic [FA_W-1:0] faddr_q;
	logic [FB_AW-1:0] cur_q, last_q;
	logic [2:0] lo_q, hi_q;

	// Combinational signals.
	logic accept, is_glyph, char_bad, rd_ok, font_ok, empty, byte_last, row_last;
	logic [3:0] gcols;
	logic signed [15:0] org_x, org_y;
	logic signed [EXT_W-1:0] x0s, x1s, y0s, y1s, jd;
	logic [LIN_W-1:0] lin_s, lin_em1;
	logic [YW-1:0] row_nxt;
	logic [6:0] c_off;
	bu_ctrl_t bu_ctrl;
	logic [7:0] glyph_row, new_byte;
	logic fb_we, fb_re, font_we, font_re;
	logic [FB_AW-1:0] fb_waddr;
	logic [7:0] fb_wdata, fb_rdata, font_rdata;

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign read_data = read_data_q;
	assign status    = status_q;

	always_comb begin
		accept   = start && !busy;
		is_glyph = (kind == KIND_GLYPH_XY) || (kind == KIND_GLYPH_PEN);
		char_bad = (char_code < FIRST_CHAR) || (char_code > LAST_CHAR);
		gcols    = (gw_q > 6'(MAX_GLYPH_COLS)) ? MAX_GLYPH_COLS : gw_q[3:0];
		org_x    = (kind == KIND_GLYPH_PEN) ? pen_x_q : pos_x;
		org_y    = (kind == KIND_GLYPH_PEN) ? pen_y_q : pos_y;
		rd_ok    = FB_CMP_W'(fb_addr) < FRAME_LIMIT;
		font_ok  = FA_W'(font_addr) < FONT_LIMIT;
		c_off    = 7'(char_q - FIRST_CHAR);

		// Clip the requested area to the panel.
		x0s   = ox_q[15] ? '0 : EXT_W'(ox_q);
		y0s   = oy_q[15] ? '0 : EXT_W'(oy_q);
		x1s   = (xe_q > X_LIMIT) ? X_LIMIT : xe_q;
		y1s   = (ye_q > Y_LIMIT) ? Y_LIMIT : ye_q;
		empty = (x1s <= x0s) || (y1s <= y0s);
		jd    = EXT_W'(y0_q) - EXT_W'(oy_q);

		lin_s     = rowbase_q + LIN_W'(x0_q);
		lin_em1   = rowbase_q + LIN_W'(x1_q) - LIN_W'(1);
		row_nxt   = row_q + YW'(1);
		byte_last = (cur_q == last_q);
		row_last  = (row_nxt == y1_q);

		bu_ctrl.ink       = ink_q;
		bu_ctrl.use_glyph = glyph_q;
		bu_ctrl.lo        = lo_q;
		bu_ctrl.hi        = byte_last ? hi_q : 3'd7;
		// Glyph column of bit 7 (the first pixel) of this byte, modulo 16; it lies in -7..7.
		bu_ctrl.off       = {cur_q[0], 3'b000} - rowbase_q[3:0] - ox_q[3:0];
		glyph_row         = font_oob_q ? 8'h00 : font_rdata;

		fb_we    = (state_q == ST_CLEAR) || (state_q == ST_BWR);
		fb_waddr = (state_q == ST_CLEAR) ? clr_q : cur_q;
		fb_wdata = (state_q == ST_CLEAR) ? FB_WHITE : new_byte;
		fb_re    = (state_q == ST_BRD) || (state_q == ST_RD);
		font_we  = accept && (kind == KIND_FONT) && font_ok;
		font_re  = (state_q == ST_ROW);
	end

	mfde_frame_ram u_frame (
		.clk   (clk),
		.we    (fb_we),
		.waddr (fb_waddr),
		.wdata (fb_wdata),
		.re    (fb_re),
		.raddr (cur_q),
		.rdata (fb_rdata)
	);

	mfde_font_ram u_font (
		.clk   (clk),
		.we    (font_we),
		.waddr (GA_W'(font_addr)),
		.wdata (font_data),
		.re    (font_re),
		.raddr (faddr_q[GA_W-1:0]),
		.rdata (font_rdata)
	);

	mfde_byte_unit u_byte (
		.ctrl      (bu_ctrl),
		.old_byte  (fb_rdata),
		.glyph_row (glyph_row),
		.new_byte  (new_byte)
	);

	// Sequencer with its registered result outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			done_q      <= 1'b0;
			read_data_q <= '0;
			status_q    <= 1'b0;
			clr_q       <= '0;
		end else begin
			done_q      <= 1'b0;
			read_data_q <= '0;
			status_q    <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + FB_AW'(1);
					if (clr_q == LAST_BYTE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (kind) inside
							KIND_FILL: begin
								state_q <= ST_SET1;
							end
							KIND_GLYPH_XY, KIND_GLYPH_PEN: begin
								if (char_bad) begin
									done_q   <= 1'b1;
									status_q <= 1'b1;
								end else begin
									state_q <= ST_SET1;
								end
							end
							KIND_READ: begin
								state_q <= ST_RD;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SET1: begin
					state_q <= ST_SET2;
				end
				ST_SET2: begin
					if (empty) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SET3;
					end
				end
				ST_SET3: begin
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					state_q <= ST_BRD;
				end
				ST_BRD: begin
					state_q <= ST_BWR;
				end
				ST_BWR: begin
					if (!byte_last) begin
						state_q <= ST_BRD;
					end else if (row_last) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ROW;
					end
				end
				ST_RD: begin
					state_q <= ST_RDOUT;
				end
				ST_RDOUT: begin
					done_q      <= 1'b1;
					read_data_q <= rd_ok_q ? fb_rdata : 8'h00;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration registers and pen.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q    <= GLYPH_DIM_RESET;
			gh_q    <= GLYPH_DIM_RESET;
			pen_x_q <= '0;
			pen_y_q <= '0;
		end else begin
			if (cfg_we && (cfg_idx == CFG_GLYPH_WIDTH)) begin
				gw_q <= cfg_wdata;
			end
			if (cfg_we && (cfg_idx == CFG_GLYPH_HEIGHT)) begin
				gh_q <= cfg_wdata;
			end
			// The pen moves even when the character is skipped.
			if (accept && (kind == KIND_GLYPH_XY)) begin
				pen_x_q <= pos_x + 16'(gw_q);
				pen_y_q <= pos_y;
			end else if (accept && (kind == KIND_GLYPH_PEN)) begin
				pen_x_q <= pen_x_q + 16'(gw_q);
			end
		end
	end

	// Datapath: operand capture, clipping, and the row and byte walk.
	always_ff @(posedge clk) begin
		if (accept) begin
			ox_q    <= org_x;
			oy_q    <= org_y;
			ink_q   <= ink;
			glyph_q <= is_glyph;
			char_q  <= char_code;
			ew_q    <= is_glyph ? 16'(gcols) : rect_w;
			eh_q    <= is_glyph ? 16'(gh_q) : rect_h;
			cur_q   <= FB_AW'(fb_addr);
			rd_ok_q <= rd_ok;
		end
		if (state_q == ST_SET1) begin
			xe_q   <= EXT_W'(ox_q) + EXT_W'(ew_q);
			ye_q   <= EXT_W'(oy_q) + EXT_W'(eh_q);
			base_q <= 13'(c_off) * 13'(gh_q);
		end
		if (state_q == ST_SET2) begin
			x0_q <= x0s[XW-1:0];
			x1_q <= x1s[XW-1:0];
			y0_q <= y0s[YW-1:0];
			y1_q <= y1s[YW-1:0];
		end
		if (state_q == ST_SET3) begin
			rowbase_q <= LIN_W'(y0_q) * ROW_STEP;
			row_q     <= y0_q;
			faddr_q   <= FA_W'(base_q) + FA_W'(jd[5:0]);
		end
		if (state_q == ST_ROW) begin
			cur_q      <= lin_s[FB_AW+2:3];
			lo_q       <= lin_s[2:0];
			last_q     <= lin_em1[FB_AW+2:3];
			hi_q       <= lin_em1[2:0];
			font_oob_q <= (faddr_q >= FONT_LIMIT);
		end
		if (state_q == ST_BWR) begin
			if (!byte_last) begin
				cur_q <= cur_q + FB_AW'(1);
				lo_q  <= 3'd0;
			end else begin
				rowbase_q <= rowbase_q + ROW_STEP;
				row_q     <= row_nxt;
				faddr_q   <= faddr_q + FA_W'(1);
			end
		end
	end

	`MFDE_ASSERT_IMP(a_done_when_idle, done, !busy)
	`MFDE_ASSERT_IMP(a_result_marked, status || (read_data != 8'h00), done)
	`MFDE_ASSERT_NEXT(a_font_load_one_cycle, start && !busy && (kind == KIND_FONT), done && !status)
	`MFDE_ASSERT_IMP(a_write_in_frame, fb_we, fb_waddr <= LAST_BYTE)
endmodule
`default_nettype wire

### tb/sv/draw_engine_checker.sv
// Checker for the monochrome framebuffer draw engine: mirrors the framebuffer, font store,
// pen and glyph size, predicts each command's result and compares it with the strobe.
// Depends on mfde_pkg for the panel geometry, command kinds and register indexes.
module draw_engine_checker import mfde_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic [2:0]         kind,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] rect_w,
	input  wire logic signed [15:0] rect_h,
	input  wire logic               ink,
	input  wire logic [7:0]         char_code,
	input  wire logic [11:0]        font_addr,
	input  wire logic [7:0]         font_data,
	input  wire logic [11:0]        fb_addr,
	input  wire logic               cfg_we,
	input  wire logic [0:0]         cfg_idx,
	input  wire logic [5:0]         cfg_wdata,
	input  wire logic               done,
	input  wire logic [7:0]         read_data,
	input  wire logic               status,
	output int                      mismatches,
	output int                      outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] read_data;
		logic       status;
	} cmd_result_t;

	logic [7:0]  frame_img [FRAME_BYTES];
	logic [7:0]  font_img [GLYPH_BYTES];
	logic [15:0] pen_col;
	logic [15:0] pen_row;
	logic [5:0]  char_w;
	logic [5:0]  char_h;
	cmd_result_t expected_q [$];

	function automatic void set_pixel(int x, int y, logic colour);
		int idx;
		if (x < 0 || x >= PANEL_WIDTH || y < 0 || y >= PANEL_HEIGHT)
			return;
		idx = x + y * PANEL_WIDTH;
		// Pixels run MSB first within a byte.
		frame_img[idx >> 3][7 - (idx & 7)] = colour;
	endfunction

	function automatic void fill_box(int x, int y, int w, int h, logic colour);
		int x0, y0, x1, y1;
		x0 = (x < 0) ? 0 : x;
		y0 = (y < 0) ? 0 : y;
		x1 = x + w;
		y1 = y + h;
		if (x1 > PANEL_WIDTH)
			x1 = PANEL_WIDTH;
		if (y1 > PANEL_HEIGHT)
			y1 = PANEL_HEIGHT;
		for (int j = y0; j < y1; j++)
			for (int i = x0; i < x1; i++)
				set_pixel(i, j, colour);
	endfunction

	function automatic logic draw_char(int x, int y, logic [7:0] code, logic colour);
		int cols, base, addr;
		logic [7:0] row_bits;
		if (code < FIRST_CHAR || code > LAST_CHAR)
			return 1'b1;
		cols = (int'(char_w) < 8) ? int'(char_w) : 8;
		base = (int'(code) - int'(FIRST_CHAR)) * int'(char_h);
		for (int j = 0; j < int'(char_h); j++) begin
			addr = base + j;
			// Glyph bytes beyond the end of the font store read as blank.
			row_bits = (addr < GLYPH_BYTES) ? font_img[addr] : 8'h00;
			for (int i = 0; i < cols; i++)
				if (row_bits[7 - i])
					set_pixel(x + i, y + j, colour);
		end
		return 1'b0;
	endfunction

	function automatic cmd_result_t apply_command();
		cmd_result_t r;
		r = '0;
		case (kind)
			KIND_FILL: fill_box(pos_x, pos_y, rect_w, rect_h, ink);
			KIND_GLYPH_XY: begin
				r.status = draw_char(pos_x, pos_y, char_code, ink);
				pen_col = 16'(int'(pos_x) + int'(char_w));
				pen_row = pos_y;
			end
			KIND_GLYPH_PEN: begin
				r.status = draw_char($signed(pen_col), $signed(pen_row), char_code, ink);
				pen_col = pen_col + 16'(char_w);
			end
			KIND_FONT: begin
				if (font_addr < GLYPH_BYTES)
					font_img[font_addr] = font_data;
			end
			KIND_READ: begin
				if (fb_addr < FRAME_BYTES)
					r.read_data = frame_img[fb_addr];
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cmd_result_t want;
		if (!arst_n) begin
			foreach (frame_img[i])
				frame_img[i] = FB_WHITE;
			foreach (font_img[i])
				font_img[i] = 8'h00;
			pen_col = '0;
			pen_row = '0;
			char_w = GLYPH_DIM_RESET;
			char_h = GLYPH_DIM_RESET;
			expected_q.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_GLYPH_WIDTH)
					char_w = cfg_wdata;
				else
					char_h = cfg_wdata;
			end
			if (start && !busy)
				expected_q.push_back(apply_command());
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result with no command outstanding: read_data %02h status %0b",
						read_data, status);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (read_data !== want.read_data) begin
						$error("read_data mismatch: expected %02h, actual %02h",
							want.read_data, read_data);
						mismatches++;
					end
					if (status !== want.status) begin
						$error("status mismatch: expected %0b, actual %0b",
							want.status, status);
						mismatches++;
					end
				end
			end
			outstanding <= expected_q.size();
		end
	end
endmodule

### tb/sv/testbench.sv
// Top of the draw engine testbench: clock, reset, command and register stimulus, verdict.
// Instantiates mono_framebuffer_draw_engine_top and draw_engine_checker; uses mfde_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mfde_pkg::*;

	localparam int         RANDOM_PER_PHASE  = 44;
	localparam int         CYCLE_LIMIT       = 20_000_000;
	localparam int         DRAIN_CYCLES      = 32;
	// A full 8x8 font: every printable character at the reset glyph height.
	localparam int         FONT_PRELOAD      = 768;
	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

	typedef struct {
		logic [2:0]         kind;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] w;
		logic signed [15:0] h;
		logic               ink;
		logic [7:0]         code;
		logic [11:0]        faddr;
		logic [7:0]         fdata;
		logic [11:0]        baddr;
	} draw_cmd_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	logic [2:0]         kind      = '0;
	logic signed [15:0] pos_x     = '0;
	logic signed [15:0] pos_y     = '0;
	logic signed [15:0] rect_w    = '0;
	logic signed [15:0] rect_h    = '0;
	logic               ink       = 1'b0;
	logic [7:0]         char_code = '0;
	logic [11:0]        font_addr = '0;
	logic [7:0]         font_data = '0;
	logic [11:0]        fb_addr   = '0;
	logic               cfg_we    = 1'b0;
	logic [0:0]         cfg_idx   = CFG_GLYPH_WIDTH;
	logic [5:0]         cfg_wdata = '0;
	logic               busy;
	logic               done;
	logic [7:0]         read_data;
	logic               status;
	int                 mismatches;
	int                 outstanding;
	int                 cycles    = 0;
	int                 pen_run   = 0;
	int                 glyph_rows = GLYPH_DIM_RESET;

	mono_framebuffer_draw_engine_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.pos_x(pos_x), .pos_y(pos_y), .rect_w(rect_w), .rect_h(rect_h), .ink(ink),
		.char_code(char_code), .font_addr(font_addr), .font_data(font_data),
		.fb_addr(fb_addr), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.done(done), .read_data(read_data), .status(status)
	);

	draw_engine_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.pos_x(pos_x), .pos_y(pos_y), .rect_w(rect_w), .rect_h(rect_h), .ink(ink),
		.char_code(char_code), .font_addr(font_addr), .font_data(font_data),
		.fb_addr(fb_addr), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.done(done), .read_data(read_data), .status(status),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("mono_framebuffer_draw_engine_top regression: fail");
			$finish;
		end
	end

	// Called at a rising edge; returns at the edge where the transfer takes place.
	task automatic issue_cmd(input draw_cmd_t c);
		start <= 1'b1;
		kind <= c.kind;
		pos_x <= c.x;
		pos_y <= c.y;
		rect_w <= c.w;
		rect_h <= c.h;
		ink <= c.ink;
		char_code <= c.code;
		font_addr <= c.faddr;
		font_data <= c.fdata;
		fb_addr <= c.baddr;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic send(input logic [2:0] k, input int x, input int y, input int w,
			input int h, input logic colour, input logic [7:0] code,
			input logic [11:0] addr, input logic [7:0] data);
		draw_cmd_t c;
		c.kind = k;
		c.x = 16'(x);
		c.y = 16'(y);
		c.w = 16'(w);
		c.h = 16'(h);
		c.ink = colour;
		c.code = code;
		c.faddr = addr;
		c.fdata = data;
		c.baddr = addr;
		issue_cmd(c);
	endtask

	task automatic pause_sender(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Lowers start and waits until every result is back and the engine is idle.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_glyph_dims(input logic [5:0] w, input logic [5:0] h);
		glyph_rows = int'(h);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_GLYPH_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_idx <= CFG_GLYPH_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly around the panel, now and then anywhere in the 16-bit range.
	function automatic logic [15:0] near_coord(input int span);
		if ($urandom_range(0, 99) < 10)
			return 16'($urandom);
		return 16'(int'($urandom_range(0, span + 24)) - 16);
	endfunction

	function automatic logic [15:0] random_extent();
		if ($urandom_range(0, 99) < 8)
			return 16'($urandom);
		return 16'(int'($urandom_range(0, 44)) - 4);
	endfunction

	// True when every row the character reads inside the font store holds a written byte:
	// the preloaded font or the last byte of the store.
	function automatic logic glyph_loaded(input logic [7:0] code, input int rows);
		int base, addr;
		base = (int'(code) - int'(FIRST_CHAR)) * rows;
		for (int j = 0; j < rows; j++) begin
			addr = base + j;
			if (addr < GLYPH_BYTES && addr >= FONT_PRELOAD && addr != GLYPH_BYTES - 1)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [7:0] random_char();
		logic [7:0] code;
		if ($urandom_range(0, 99) < 15) begin
			if ($urandom_range(0, 1) == 0)
				return 8'($urandom_range(0, int'(FIRST_CHAR) - 1));
			return 8'($urandom_range(int'(LAST_CHAR) + 1, 255));
		end
		repeat (16) begin
			code = 8'($urandom_range(FIRST_CHAR, LAST_CHAR));
			if (glyph_loaded(code, glyph_rows))
				return code;
		end
		return FIRST_CHAR;
	endfunction

	// Glyphs at x,y are usually followed by a run of pen glyphs, as a string would be.
	function automatic draw_cmd_t random_cmd();
		draw_cmd_t c;
		int pick;
		c.x = near_coord(PANEL_WIDTH);
		c.y = near_coord(PANEL_HEIGHT);
		c.w = random_extent();
		c.h = random_extent();
		c.ink = 1'($urandom_range(0, 1));
		c.code = random_char();
		c.faddr = 12'($urandom);
		c.fdata = 8'($urandom);
		c.baddr = 12'($urandom);
		pick = $urandom_range(0, 99);
		if (pen_run > 0) begin
			c.kind = KIND_GLYPH_PEN;
			pen_run--;
		end else if (pick < 25) begin
			c.kind = KIND_FILL;
		end else if (pick < 45) begin
			c.kind = KIND_GLYPH_XY;
			pen_run = $urandom_range(0, 8);
		end else if (pick < 55) begin
			c.kind = KIND_GLYPH_PEN;
		end else if (pick < 65) begin
			c.kind = KIND_FONT;
		end else if (pick < 97) begin
			c.kind = KIND_READ;
		end else begin
			c.kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
		end
		return c;
	endfunction

	task automatic run_phase(input logic [5:0] w, input logic [5:0] h, input int pct);
		settle();
		write_glyph_dims(w, h);
		repeat (RANDOM_PER_PHASE) begin
			pause_sender(pct);
			issue_cmd(random_cmd());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// The engine sweeps the framebuffer to white before it takes a command.
		settle();
		write_glyph_dims(GLYPH_DIM_RESET, GLYPH_DIM_RESET);

		// A full 8x8 font is loaded first; characters are then chosen so that no glyph
		// ever reads a font byte that was never written.
		for (int a = 0; a < FONT_PRELOAD; a++)
			send(KIND_FONT, 0, 0, 0, 0, 1'b0, 8'h00, 12'(a), 8'($urandom));

		send(KIND_READ, 0, 0, 0, 0, 1'b0, 8'h00, 12'h000, 8'h00);
		send(KIND_FILL, -1, -1, 32767, 32767, 1'b0, 8'h00, 12'h000, 8'h00);
		send(KIND_READ, 0, 0, 0, 0, 1'b0, 8'h00, 12'hFFF, 8'h00);
		send(KIND_FILL, -5, -5, 20, 12, 1'b1, 8'h00, 12'h000, 8'h00);
		send(KIND_FILL, 10, 10, 0, 5, 1'b1, 8'h00, 12'h000, 8'h00);
		send(KIND_FILL, 10, 10, 5, -1, 1'b1, 8'h00, 12'h000, 8'h00);
		send(KIND_FILL, -32768, -32768, 32767, 32767, 1'b1, 8'h00, 12'h000, 8'h00);
		send(KIND_FILL, -32768, -32768, -32768, -32768, 1'b1, 8'h00, 12'h000, 8'h00);
		send(KIND_FILL, 32767, 32767, 32767, 32767, 1'b1, 8'h00, 12'h000, 8'h00);
		send(KIND_FILL, 121, 250, 32767, 32767, 1'b1, 8'h00, 12'h000, 8'h00);
		send(KIND_READ, 0, 0, 0, 0, 1'b0, 8'h00, 12'hFFF, 8'h00);
		send(KIND_READ, 0, 0, 0, 0, 1'b0, 8'h00, 12'h001, 8'h00);
		send(KIND_GLYPH_XY, -3, -2, 0, 0, 1'b1, 8'h41, 12'h000, 8'h00);
		send(KIND_GLYPH_XY, 124, 252, 0, 0, 1'b1, LAST_CHAR, 12'h000, 8'h00);
		// Characters outside the printable range are skipped but still move the pen.
		send(KIND_GLYPH_XY, 40, 40, 0, 0, 1'b1, 8'h1F, 12'h000, 8'h00);
		send(KIND_GLYPH_PEN, 0, 0, 0, 0, 1'b1, 8'h80, 12'h000, 8'h00);
		send(KIND_GLYPH_PEN, 0, 0, 0, 0, 1'b1, 8'hFF, 12'h000, 8'h00);
		send(KIND_GLYPH_PEN, 0, 0, 0, 0, 1'b0, 8'h00, 12'h000, 8'h00);
		send(KIND_GLYPH_PEN, 0, 0, 0, 0, 1'b1, FIRST_CHAR, 12'h000, 8'h00);
		send(KIND_GLYPH_PEN, 0, 0, 0, 0, 1'b1, 8'h5A, 12'h000, 8'h00);
		send(KIND_READ, 0, 0, 0, 0, 1'b0, 8'h00, 12'd645, 8'h00);
		// The pen wraps from the right-hand edge of the 16-bit range to far left.
		send(KIND_GLYPH_XY, 32767, 100, 0, 0, 1'b1, 8'h48, 12'h000, 8'h00);
		send(KIND_GLYPH_PEN, 0, 0, 0, 0, 1'b1, 8'h69, 12'h000, 8'h00);
		send(KIND_FONT, 0, 0, 0, 0, 1'b0, 8'h00, 12'hFFF, 8'hFF);
		send(KIND_FONT, 0, 0, 0, 0, 1'b0, 8'h00, 12'h000, 8'h00);
		send(KIND_UNUSED_FIRST, 0, 0, 0, 0, 1'b1, 8'h41, 12'h123, 8'hA5);
		send(KIND_UNUSED_LAST, 0, 0, 0, 0, 1'b1, 8'h41, 12'h123, 8'hA5);

		run_phase(6'd8, 6'd8, 0);
		run_phase(6'd1, 6'd1, 53);
		run_phase(6'd32, 6'd32, 12);
		// The tallest glyphs run past the end of the font store for high characters.
		run_phase(6'd63, 6'd63, 0);
		run_phase(6'd0, 6'd0, 53);
		run_phase(6'd5, 6'd13, 12);
		run_phase(6'd8, 6'd32, 53);
		run_phase(6'd8, 6'd8, 0);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("mono_framebuffer_draw_engine_top regression: pass");
		else
			$display("mono_framebuffer_draw_engine_top regression: fail");
		$finish;
	end
endmodule
